>>> rtl/bxs_pkg.sv
// Package for the branch cross-reference scanner: codes, opcode constants and
// the structs passed between the scanner's modules. Depends on nothing.
package bxs_pkg;

	// Configuration register indexes and port widths.
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 64;
	localparam logic [CFG_INDEX_W-1:0] REG_ARCH_MODE    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BASE_ADDRESS = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_STORE_CAP    = 2'd2;

	// Architecture modes.
	localparam logic [1:0] MODE_X86   = 2'd0;
	localparam logic [1:0] MODE_ARM64 = 2'd1;
	localparam logic [1:0] MODE_ARM   = 2'd2;
	localparam logic [1:0] MODE_NONE  = 2'd3;

	// Pending x86 branch kinds.
	localparam logic [1:0] PEND_NONE = 2'd0;
	localparam logic [1:0] PEND_CALL = 2'd1;
	localparam logic [1:0] PEND_JUMP = 2'd2;

	// Opcodes and masks.
	localparam logic [7:0]  OPC_X86_CALL = 8'hE8;
	localparam logic [7:0]  OPC_X86_JMP  = 8'hE9;
	localparam logic [31:0] A64_OP_MASK  = 32'hFC00_0000;
	localparam logic [31:0] A64_OP_BL    = 32'h9400_0000;
	localparam logic [31:0] A64_OP_B     = 32'h1400_0000;
	localparam logic [31:0] A64_IMM_MASK = 32'h03FF_FFFF;
	localparam logic [31:0] A32_OP_MASK  = 32'hFF00_0000;
	localparam logic [31:0] A32_OP_BL    = 32'hEB00_0000;
	localparam logic [31:0] A32_OP_B     = 32'hEA00_0000;
	localparam logic [31:0] A32_IMM_MASK = 32'h00FF_FFFF;

	localparam logic [31:0] CNT_MAX       = 32'hFFFF_FFFF;
	localparam logic [31:0] CAP_RESET     = 32'hFFFF_FFFF;
	localparam logic [63:0] X86_NEXT_INSN = 64'd5;
	localparam logic [63:0] A32_PC_AHEAD  = 64'd8;

	typedef struct packed {
		logic [1:0]  arch_mode;
		logic [63:0] base_address;
		logic [31:0] store_cap;
	} cfg_t;

	// A decoded byte: whether it completed a branch, and the parts of its target.
	typedef struct packed {
		logic        valid;
		logic        cand;
		logic        jump;
		logic        last;
		logic [63:0] from;
		logic [63:0] addend;
	} cand_t;

	typedef struct packed {
		logic        is_end;
		logic [63:0] from_address;
		logic [63:0] to_address;
		logic        is_jump;
		logic        is_stored;
		logic [31:0] found_count;
	} rec_t;

	// Up to two records written into the output queue in one cycle.
	typedef struct packed {
		logic wr0;
		logic wr1;
		rec_t rec0;
		rec_t rec1;
	} push_t;

endpackage

>>> rtl/bxs_if.sv
// Valid/ready channel interfaces for the scanner's byte input and record output.
// Self-contained; no package needed.
interface bxs_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] code_byte;
	logic       last_byte;

	modport source (output valid, output code_byte, output last_byte, input ready);
	modport sink (input valid, input code_byte, input last_byte, output ready);
endinterface

interface bxs_out_if;
	logic        valid;
	logic        ready;
	logic        is_end;
	logic [63:0] from_address;
	logic [63:0] to_address;
	logic        is_jump;
	logic        is_stored;
	logic [31:0] found_count;

	modport source (output valid, output is_end, output from_address, output to_address,
		output is_jump, output is_stored, output found_count, input ready);
	modport sink (input valid, input is_end, input from_address, input to_address,
		input is_jump, input is_stored, input found_count, output ready);
endinterface

>>> rtl/bxs_decode.sv
// First stage of the scanner: byte offset, instruction assembly and opcode decode.
// Depends on bxs_pkg.
module bxs_decode import bxs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       mode_wr,
	input  logic       accept,
	input  logic [7:0] code_byte,
	input  logic       last_byte,
	output cand_t      cand_s1
);

	logic [63:0] offset_q, offset_n;
	logic [23:0] ob_q, ob_n, ob_ins;
	logic [1:0]  bc_q, bc_n;
	logic [1:0]  pend_q, pend_n;
	logic [63:0] from_q, from_n;

	logic [63:0] here, cur_from;
	logic [31:0] word, op;
	cand_t       c;

	assign here = cfg.base_address + offset_q;
	assign word = {code_byte, ob_q};
	assign cur_from = (bc_q == 2'd0) ? here : from_q;

	always_comb begin
		case (bc_q)
			2'd0:    ob_ins = {ob_q[23:8], code_byte};
			2'd1:    ob_ins = {ob_q[23:16], code_byte, ob_q[7:0]};
			2'd2:    ob_ins = {code_byte, ob_q[15:0]};
			default: ob_ins = ob_q;
		endcase
	end

	always_comb begin
		offset_n = offset_q + 64'd1;
		ob_n     = ob_q;
		bc_n     = bc_q;
		pend_n   = pend_q;
		from_n   = from_q;
		op       = '0;
		c        = '0;
		c.valid  = 1'b1;
		c.last   = last_byte;
		c.from   = from_q;

		unique case (cfg.arch_mode) inside
			MODE_X86: begin
				if (pend_q != PEND_NONE) begin
					if (bc_q == 2'd3) begin
						c.cand   = 1'b1;
						c.jump   = (pend_q == PEND_JUMP);
						c.addend = {{32{word[31]}}, word} + X86_NEXT_INSN;
						ob_n     = '0;
						bc_n     = '0;
						pend_n   = PEND_NONE;
						from_n   = '0;
					end else begin
						ob_n = ob_ins;
						bc_n = bc_q + 2'd1;
					end
				end else if (code_byte == OPC_X86_CALL || code_byte == OPC_X86_JMP) begin
					pend_n = (code_byte == OPC_X86_JMP) ? PEND_JUMP : PEND_CALL;
					from_n = here;
					ob_n   = '0;
					bc_n   = '0;
				end
			end
			MODE_ARM64, MODE_ARM: begin
				if (bc_q == 2'd3) begin
					c.from = cur_from;
					if (cfg.arch_mode == MODE_ARM64) begin
						op       = word & A64_OP_MASK;
						c.cand   = (op == A64_OP_BL) || (op == A64_OP_B);
						c.jump   = (op == A64_OP_B);
						c.addend = {{36{word[25]}}, word[25:0], 2'b00};
					end else begin
						op       = word & A32_OP_MASK;
						c.cand   = (op == A32_OP_BL) || (op == A32_OP_B);
						c.jump   = (op == A32_OP_B);
						c.addend = {{38{word[23]}}, word[23:0], 2'b00} + A32_PC_AHEAD;
					end
					ob_n   = '0;
					bc_n   = '0;
					pend_n = PEND_NONE;
					from_n = '0;
				end else begin
					ob_n   = ob_ins;
					bc_n   = bc_q + 2'd1;
					from_n = cur_from;
				end
			end
			default: begin
			end
		endcase

		// The end of an image restarts offset and assembly for the next one.
		if (last_byte) begin
			offset_n = '0;
			ob_n     = '0;
			bc_n     = '0;
			pend_n   = PEND_NONE;
			from_n   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			ob_q     <= '0;
			bc_q     <= '0;
			pend_q   <= PEND_NONE;
			from_q   <= '0;
			cand_s1  <= '0;
		end else begin
			cand_s1 <= accept ? c : '0;
			if (accept) begin
				offset_q <= offset_n;
				ob_q     <= ob_n;
				bc_q     <= bc_n;
				pend_q   <= pend_n;
				from_q   <= from_n;
			end else if (mode_wr) begin
				ob_q   <= '0;
				bc_q   <= '0;
				pend_q <= PEND_NONE;
				from_q <= '0;
			end
		end
	end

endmodule

>>> rtl/bxs_resolve.sv
// Second stage: target addition, zero-target filter, saturating count
// and the records written into the output queue. Depends on bxs_pkg.
module bxs_resolve import bxs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cand_t       cand_s1,
	input  logic [31:0] store_cap,
	output logic        busy_s2,
	output push_t       push
);

	logic        valid_s2, cand_s2, jump_s2, last_s2;
	logic [63:0] from_s2, to_s2;
	logic [31:0] total_q;

	logic        is_ref, sat, stored;
	logic [31:0] count_ref, count_after;
	rec_t        rec_ref, rec_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			total_q  <= '0;
		end else begin
			valid_s2 <= cand_s1.valid;
			if (valid_s2) begin
				total_q <= last_s2 ? '0 : count_after;
			end
		end
	end

	always_ff @(posedge clk) begin
		cand_s2 <= cand_s1.cand;
		jump_s2 <= cand_s1.jump;
		last_s2 <= cand_s1.last;
		from_s2 <= cand_s1.from;
		to_s2   <= cand_s1.from + cand_s1.addend;
	end

	assign busy_s2 = valid_s2;

	// A zero target is dropped; a saturated total is never flagged stored.
	assign is_ref      = cand_s2 && (to_s2 != 64'd0);
	assign sat         = (total_q == CNT_MAX);
	assign count_ref   = sat ? total_q : total_q + 32'd1;
	assign stored      = !sat && (total_q < store_cap);
	assign count_after = is_ref ? count_ref : total_q;

	always_comb begin
		rec_ref              = '0;
		rec_ref.from_address = from_s2;
		rec_ref.to_address   = to_s2;
		rec_ref.is_jump      = jump_s2;
		rec_ref.is_stored    = stored;
		rec_ref.found_count  = count_ref;
		rec_end              = '0;
		rec_end.is_end       = 1'b1;
		rec_end.found_count  = count_after;

		push.wr0  = valid_s2 && (is_ref || last_s2);
		push.rec0 = is_ref ? rec_ref : rec_end;
		push.wr1  = valid_s2 && is_ref && last_s2;
		push.rec1 = rec_end;
	end

endmodule

>>> rtl/bxs_out_fifo.sv
// Output record queue that takes up to two records a cycle and gives one.
// Depends on bxs_pkg.
module bxs_out_fifo import bxs_pkg::*; #(
	parameter int DEPTH = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  push_t                      push,
	input  logic                       pop,
	output rec_t                       head,
	output logic                       not_empty,
	output logic [$clog2(DEPTH+1)-1:0] level
);

	localparam int PTR_W   = $clog2(DEPTH);
	localparam int LEVEL_W = $clog2(DEPTH + 1);

	rec_t             mem [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q, wr_next;
	logic [LEVEL_W-1:0] level_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign wr_next   = ptr_inc(wr_q);
	assign head      = mem[rd_q];
	assign not_empty = (level_q != '0);
	assign level     = level_q;

	always_ff @(posedge clk) begin
		if (push.wr0) begin
			mem[wr_q] <= push.rec0;
		end
		if (push.wr1) begin
			mem[wr_next] <= push.rec1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
		end else begin
			if (push.wr1) begin
				wr_q <= ptr_inc(wr_next);
			end else if (push.wr0) begin
				wr_q <= wr_next;
			end
			if (pop) begin
				rd_q <= ptr_inc(rd_q);
			end
			level_q <= level_q + LEVEL_W'(push.wr0) + LEVEL_W'(push.wr1) - LEVEL_W'(pop);
		end
	end

endmodule

>>> rtl/branch_xref_scanner_unit.sv
// Branch cross-reference scanner: finds direct calls and jumps in a byte stream.
// A record passes the decode and resolve registers before it is written into the queue.
// Throughput: one byte a cycle; ready falls only when the record queue level plus two
// records for the offered byte and for each byte in the two stages would pass FIFO_DEPTH.
// Reset (arst_n, asynchronous): registers to reset values, scan state cleared, queue empty.
// Depends on bxs_pkg, bxs_if, bxs_decode, bxs_resolve and bxs_out_fifo.
module branch_xref_scanner_unit import bxs_pkg::*; #(
	parameter int FIFO_DEPTH = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	bxs_in_if.sink                 in_ch,
	bxs_out_if.source              out_ch
);

	localparam int LEVEL_W = $clog2(FIFO_DEPTH + 1);
	localparam int RES_W   = LEVEL_W + 2;

	// The configuration registers. Writing the mode also drops any half-built instruction
	// unless a byte is accepted in the same cycle; the decode stage sees it on mode_wr.
	cfg_t  cfg_q;
	logic  mode_wr;

	// Pipeline signals between the stages and the queue.
	cand_t              cand_s1;
	logic               busy_s2;
	push_t              push;
	rec_t               head;
	logic               not_empty;
	logic [LEVEL_W-1:0] fifo_level;
	logic [RES_W-1:0]   reserved;
	logic               in_accept;
	logic               out_pop;

	assign mode_wr = cfg_we && (cfg_index == REG_ARCH_MODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.arch_mode    <= MODE_X86;
			cfg_q.base_address <= '0;
			cfg_q.store_cap    <= CAP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ARCH_MODE:    cfg_q.arch_mode    <= cfg_data[1:0];
				REG_BASE_ADDRESS: cfg_q.base_address <= cfg_data;
				REG_STORE_CAP:    cfg_q.store_cap    <= cfg_data[31:0];
				default: begin
				end
			endcase
		end
	end

	// Every byte may leave two records (a reference and the end record), so each
	// byte still in the stages holds two places of the queue. The pipeline itself
	// never stalls; this reservation is the only flow control on the input.
	assign reserved = RES_W'(fifo_level)
		+ (cand_s1.valid ? RES_W'(2) : RES_W'(0))
		+ (busy_s2 ? RES_W'(2) : RES_W'(0));
	assign in_ch.ready = (reserved <= RES_W'(FIFO_DEPTH - 2));
	assign in_accept   = in_ch.valid && in_ch.ready;

	bxs_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.mode_wr   (mode_wr),
		.accept    (in_accept),
		.code_byte (in_ch.code_byte),
		.last_byte (in_ch.last_byte),
		.cand_s1   (cand_s1)
	);

	bxs_resolve u_resolve (
		.clk       (clk),
		.arst_n    (arst_n),
		.cand_s1   (cand_s1),
		.store_cap (cfg_q.store_cap),
		.busy_s2   (busy_s2),
		.push      (push)
	);

	bxs_out_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (out_pop),
		.head      (head),
		.not_empty (not_empty),
		.level     (fifo_level)
	);

	// The queue head drives the output channel directly; a transfer pops it.
	assign out_ch.valid        = not_empty;
	assign out_ch.is_end       = head.is_end;
	assign out_ch.from_address = head.from_address;
	assign out_ch.to_address   = head.to_address;
	assign out_ch.is_jump      = head.is_jump;
	assign out_ch.is_stored    = head.is_stored;
	assign out_ch.found_count  = head.found_count;
	assign out_pop             = out_ch.valid && out_ch.ready;

`ifndef SYNTH
	// The input reservation must keep the queue from ever overflowing.
	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(fifo_level) + int'(push.wr0) + int'(push.wr1)) <= FIFO_DEPTH)
		else $error("record queue overflow");

	// The final byte of an image always gives an end record once it has passed both stage registers.
	a_end_record: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && in_ch.last_byte) |-> ##2
		(push.wr0 && (push.rec0.is_end || (push.wr1 && push.rec1.is_end))))
		else $error("end record missing after last byte");

	// A second record in one cycle is only an end record following a reference.
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.wr1 |-> (push.wr0 && !push.rec0.is_end && push.rec1.is_end))
		else $error("bad record pair order");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for branch_xref_scanner_unit. Drives code images byte by byte and
// checks every record against a cycle-free model kept here. Depends on bxs_pkg and bxs_if.
module tb;
	import bxs_pkg::*;

	// Register index that the block does not decode; writes to it must have no effect.
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
	// Cycles allowed after the last expected record before the block counts as idle.
	// This leaves a margin over the decode and resolve registers that a byte passes through.
	localparam int SETTLE_CYCLES = 10;
	// Length of the long receiver hold-off that forces the record queue to fill.
	localparam int LONG_HOLD = 300;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	bxs_in_if in_ch();
	bxs_out_if out_ch();

	branch_xref_scanner_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always #4 clk = ~clk;

	// Model of the scanner: configuration copy and scan state.
	logic [1:0] scan_mode;
	logic [63:0] scan_base;
	logic [31:0] scan_cap;
	logic [63:0] scan_offset;
	logic [31:0] scan_word;
	logic [2:0] scan_fill;
	logic [1:0] scan_pending;
	logic [63:0] scan_from;
	logic [31:0] scan_total;

	// Records the model has produced and the block has not yet delivered, oldest first.
	rec_t xrefs_due[$];

	int unsigned faults = 0;
	bit sender_idling = 1'b1;
	bit receiver_idling = 1'b1;
	int unsigned hold_left = 0;
	int unsigned stall_left = 0;

	// ------------------------------------------------------------------
	// Model
	// ------------------------------------------------------------------

	// Throws away whatever instruction is partly assembled.
	task automatic drop_partial();
		scan_word = '0;
		scan_fill = '0;
		scan_pending = PEND_NONE;
		scan_from = '0;
	endtask

	// Counts one reference and queues its record. A zero target is not a reference at all,
	// so it is neither counted nor reported. Once the count has saturated it stays there and
	// the record is never marked as stored.
	task automatic count_xref(input logic [63:0] src, input logic [63:0] dst, input logic jump);
		rec_t xref;
		if (dst == 64'd0)
			return;
		xref = '0;
		if (scan_total == CNT_MAX) begin
			xref.is_stored = 1'b0;
		end else begin
			scan_total++;
			xref.is_stored = scan_total <= scan_cap;
		end
		xref.from_address = src;
		xref.to_address = dst;
		xref.is_jump = jump;
		xref.found_count = scan_total;
		xrefs_due = {xrefs_due, xref};
	endtask

	// Advances the model by one accepted byte and queues the records it gives rise to.
	task automatic scan_byte(input logic [7:0] code, input logic last);
		logic [63:0] here;
		rec_t closing;
		here = scan_base + scan_offset;
		case (scan_mode)
			MODE_X86: begin
				if (scan_pending != PEND_NONE) begin
					// Gathering the rel32 operand, least significant byte first.
					scan_word[8*scan_fill[1:0] +: 8] = code;
					scan_fill++;
					if (scan_fill == 3'd4) begin
						count_xref(scan_from,
							scan_from + X86_NEXT_INSN + {{32{scan_word[31]}}, scan_word},
							scan_pending == PEND_JUMP);
						drop_partial();
					end
				end else if (code == OPC_X86_CALL || code == OPC_X86_JMP) begin
					scan_pending = (code == OPC_X86_JMP) ? PEND_JUMP : PEND_CALL;
					scan_from = here;
					scan_word = '0;
					scan_fill = '0;
				end
			end
			MODE_ARM64, MODE_ARM: begin
				// Words are aligned to the point where assembly last restarted.
				if (scan_fill == 3'd0) begin
					scan_from = here;
					scan_word = '0;
				end
				scan_word[8*scan_fill[1:0] +: 8] = code;
				scan_fill++;
				if (scan_fill == 3'd4) begin
					if (scan_mode == MODE_ARM64) begin
						if ((scan_word & A64_OP_MASK) == A64_OP_BL ||
								(scan_word & A64_OP_MASK) == A64_OP_B)
							count_xref(scan_from,
								scan_from + {{36{scan_word[25]}}, scan_word[25:0], 2'b00},
								(scan_word & A64_OP_MASK) == A64_OP_B);
					end else begin
						if ((scan_word & A32_OP_MASK) == A32_OP_BL ||
								(scan_word & A32_OP_MASK) == A32_OP_B)
							count_xref(scan_from, scan_from + A32_PC_AHEAD +
								{{38{scan_word[23]}}, scan_word[23:0], 2'b00},
								(scan_word & A32_OP_MASK) == A32_OP_B);
					end
					drop_partial();
				end
			end
			default: ;
		endcase
		scan_offset++;
		// The end record follows any reference completed by the same byte. A partly
		// assembled instruction at the end of the image simply vanishes.
		if (last) begin
			closing = '0;
			closing.is_end = 1'b1;
			closing.found_count = scan_total;
			xrefs_due = {xrefs_due, closing};
			scan_offset = '0;
			scan_total = '0;
			drop_partial();
		end
	endtask

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	// Offers one byte and holds it until the block takes it. Idle gaps are inserted at random
	// while the sender is allowed to idle; otherwise valid stays high from one transfer to
	// the next.
	task automatic push_byte(input logic [7:0] code, input logic last);
		int unsigned gap;
		gap = (sender_idling && $urandom_range(0, 4) == 0) ? $urandom_range(1, 7) : 0;
		@(negedge clk);
		if (gap != 0) begin
			in_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.code_byte = code;
		in_ch.last_byte = last;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		scan_byte(code, last);
	endtask

	task automatic send_run(input logic [7:0] seq[$], input logic ends_image);
		foreach (seq[i])
			push_byte(seq[i], ends_image && i == seq.size() - 1);
	endtask

	// Stops offering bytes and waits until every expected record has been transferred,
	// then waits out the settle time so that bytes that produce nothing have left the pipeline.
	task automatic wait_idle();
		@(negedge clk);
		in_ch.valid = 1'b0;
		while (xrefs_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Writes one register with the block idle and mirrors the write in the model.
	task automatic set_reg(input logic [CFG_INDEX_W-1:0] index, input logic [63:0] value);
		wait_idle();
		cfg_we = 1'b1;
		cfg_index = index;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		case (index)
			REG_ARCH_MODE: begin
				scan_mode = value[1:0];
				drop_partial();
			end
			REG_BASE_ADDRESS: scan_base = value;
			REG_STORE_CAP: scan_cap = value[31:0];
			default: ;
		endcase
	endtask

	task automatic configure(input logic [1:0] mode, input logic [63:0] base,
			input logic [31:0] cap);
		set_reg(REG_ARCH_MODE, {62'd0, mode});
		set_reg(REG_BASE_ADDRESS, base);
		set_reg(REG_STORE_CAP, {32'd0, cap});
	endtask

	// Builds one random image for the current mode and sends it, last byte marked.
	// In a scanning mode most of it is well-formed branches with random displacements; the rest
	// is filler, and now and then the image stops part way through an instruction.
	task automatic send_image(input int unsigned n_insns);
		logic [7:0] seq[$];
		logic [63:0] here;
		logic [31:0] word;
		int unsigned pick;
		for (int i = 0; i < n_insns; i++) begin
			here = scan_base + scan_offset + 64'(seq.size());
			pick = $urandom_range(0, 9);
			case (scan_mode)
				MODE_X86: begin
					if (pick < 6) begin
						seq = {seq, (pick[0] ? OPC_X86_JMP : OPC_X86_CALL)};
						// Aim at address zero now and then, else short or arbitrary hops.
						if (pick == 0)
							word = 32'(-(here + X86_NEXT_INSN));
						else if (pick < 4)
							word = 32'($urandom_range(0, 4095)) - 32'd2048;
						else
							word = $urandom;
						for (int k = 0; k < 4; k++)
							seq = {seq, word[8*k +: 8]};
					end else begin
						repeat ($urandom_range(1, 4)) seq = {seq, 8'($urandom)};
					end
				end
				MODE_ARM64, MODE_ARM: begin
					if (pick < 6) begin
						if (pick == 0)
							word = (scan_mode == MODE_ARM64) ? 32'((-here) >> 2) :
								32'((-(here + A32_PC_AHEAD)) >> 2);
						else if (pick < 4)
							word = 32'($urandom_range(0, 511)) - 32'd256;
						else
							word = $urandom;
						if (scan_mode == MODE_ARM64)
							word = (pick[0] ? A64_OP_B : A64_OP_BL) | (word & A64_IMM_MASK);
						else
							word = (pick[0] ? A32_OP_B : A32_OP_BL) | (word & A32_IMM_MASK);
					end else begin
						word = $urandom;
					end
					for (int k = 0; k < 4; k++)
						seq = {seq, word[8*k +: 8]};
				end
				default: seq = {seq, 8'($urandom)};
			endcase
		end
		if ($urandom_range(0, 2) == 0) begin
			if (scan_mode == MODE_X86)
				seq = {seq, ($urandom_range(0, 1) ? OPC_X86_JMP : OPC_X86_CALL)};
			repeat ($urandom_range(1, 3)) seq = {seq, 8'($urandom)};
		end
		if (seq.size() == 0)
			seq = {seq, 8'($urandom)};
		send_run(seq, 1'b1);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset settings: x86, base zero, no cap. A jump landing on zero, the largest forward
	// and backward displacements with a reference on the closing byte, an opcode byte
	// used as operand, and an opcode whose operand is cut short by the end of the image.
	task automatic test_x86_directed();
		logic [7:0] seq[$];
		seq = {8'hE9, 8'hFB, 8'hFF, 8'hFF, 8'hFF, 8'hE8, 8'hFF, 8'hFF, 8'hFF, 8'h7F,
			8'hE9, 8'h00, 8'h00, 8'h00, 8'h80};
		send_run(seq, 1'b1);
		seq = {8'hE8, 8'hE9, 8'hE8, 8'hE9, 8'hE8, 8'hE8, 8'h01, 8'h02};
		send_run(seq, 1'b1);
	endtask

	// Base just below the top of the address space, so targets wrap; a cap of one so the
	// second reference is not stored. The last branch lands on zero after wrapping, and
	// the image ends with a lone byte of an unfinished word.
	task automatic test_arm64_directed();
		logic [7:0] seq[$];
		configure(MODE_ARM64, 64'hFFFF_FFFF_FFFF_FFF8, 32'd1);
		seq = {8'h01, 8'h00, 8'h00, 8'h94, 8'hFF, 8'hFF, 8'hFF, 8'h17,
			8'h00, 8'h00, 8'h00, 8'h14, 8'h55};
		send_run(seq, 1'b1);
	endtask

	// A branch with link, then a plain branch whose PC-relative target is exactly zero.
	task automatic test_arm_directed();
		logic [7:0] seq[$];
		configure(MODE_ARM, 64'd0, CAP_RESET);
		seq = {8'h00, 8'h00, 8'h00, 8'hEB, 8'hFD, 8'hFF, 8'hFF, 8'hEA};
		send_run(seq, 1'b1);
	endtask

	// With scanning off, even a valid call gives only the end record.
	task automatic test_no_scan();
		logic [7:0] seq[$];
		configure(MODE_NONE, 64'h0000_0000_0040_0000, 32'd0);
		seq = {8'hE8, 8'h01, 8'h00, 8'h00, 8'h00};
		send_run(seq, 1'b1);
	endtask

	// A mode write in the middle of an x86 call discards it; ARM64 words then line up
	// from the next byte. A write to the undecoded index must change nothing.
	task automatic test_mode_switch();
		logic [7:0] seq[$];
		configure(MODE_X86, 64'h0000_7FFF_0000_1000, 32'd5);
		seq = {8'hE8, 8'h11, 8'h22};
		send_run(seq, 1'b0);
		set_reg(REG_ARCH_MODE, {62'd0, MODE_ARM64});
		set_reg(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
		seq = {8'h01, 8'h00, 8'h00, 8'h94, 8'h02, 8'h00, 8'h00, 8'h14};
		send_run(seq, 1'b1);
	endtask

	// The receiver stops for a long stretch while the sender streams calls back to back,
	// so the record queue fills and the block has to hold off its input.
	task automatic test_backpressure();
		logic [7:0] seq[$];
		configure(MODE_X86, 64'h1000, 32'd3);
		sender_idling = 1'b0;
		@(posedge clk);
		hold_left = LONG_HOLD;
		repeat (30) seq = {seq, 8'hE8, 8'h01, 8'h00, 8'h00, 8'h00};
		send_run(seq, 1'b1);
		sender_idling = 1'b1;
	endtask

	task automatic test_random_x86();
		configure(MODE_X86, 64'd0, 32'd3);
		repeat (6) send_image($urandom_range(1, 12));
	endtask

	task automatic test_random_arm64();
		configure(MODE_ARM64, 64'hFFFF_FFFF_FFFF_FF00, 32'd0);
		repeat (5) send_image($urandom_range(1, 12));
	endtask

	task automatic test_random_arm();
		configure(MODE_ARM, 64'd0, CAP_RESET);
		repeat (5) send_image($urandom_range(1, 12));
	endtask

	// Every image under fresh settings, the extremes of base and cap among them.
	task automatic test_random_mixed(input int unsigned n_images);
		logic [63:0] base;
		logic [31:0] cap;
		repeat (n_images) begin
			case ($urandom_range(0, 3))
				0: base = 64'd0;
				1: base = 64'hFFFF_FFFF_FFFF_FFFF;
				2: base = 64'($urandom_range(0, 65535));
				default: base = {$urandom, $urandom};
			endcase
			case ($urandom_range(0, 3))
				0: cap = 32'd0;
				1: cap = 32'($urandom_range(1, 8));
				2: cap = CAP_RESET;
				default: cap = $urandom;
			endcase
			configure(2'($urandom_range(0, 3)), base, cap);
			send_image($urandom_range(1, 12));
		end
	endtask

	// ------------------------------------------------------------------
	// Receiver: random stall bursts, plus the long hold-off when one is requested.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_left != 0) begin
			out_ch.ready = 1'b0;
			hold_left--;
		end else if (stall_left != 0) begin
			out_ch.ready = 1'b0;
			stall_left--;
		end else if (receiver_idling && $urandom_range(0, 5) == 0) begin
			out_ch.ready = 1'b0;
			stall_left = $urandom_range(0, 6);
		end else begin
			out_ch.ready = 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Checker: every record transferred is compared with the oldest one outstanding.
	// ------------------------------------------------------------------
	function automatic void check_field(input string field, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			faults++;
			if (faults <= 10)
				$display("%0t ns: %s expected %h, got %h", $time, field, want, got);
		end
	endfunction

	always @(posedge clk) begin
		rec_t want;
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (xrefs_due.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("%0t ns: record transferred with none outstanding", $time);
			end else begin
				want = xrefs_due.pop_front();
				check_field("is_end", 64'(want.is_end), 64'(out_ch.is_end));
				check_field("from_address", want.from_address, out_ch.from_address);
				check_field("to_address", want.to_address, out_ch.to_address);
				check_field("is_jump", 64'(want.is_jump), 64'(out_ch.is_jump));
				check_field("is_stored", 64'(want.is_stored), 64'(out_ch.is_stored));
				check_field("found_count", 64'(want.found_count), 64'(out_ch.found_count));
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequence of tests
	// ------------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.code_byte = '0;
		in_ch.last_byte = 1'b0;
		out_ch.ready = 1'b0;
		scan_mode = MODE_X86;
		scan_base = '0;
		scan_cap = CAP_RESET;
		scan_offset = '0;
		scan_total = '0;
		drop_partial();
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		test_x86_directed();
		test_arm64_directed();
		test_arm_directed();
		test_no_scan();
		test_mode_switch();
		test_backpressure();
		test_random_x86();
		test_random_arm64();
		test_random_arm();
		test_random_mixed(4);
		// The closing stretch runs with no sender gaps and no random receiver stalls.
		sender_idling = 1'b0;
		receiver_idling = 1'b0;
		test_random_mixed(4);

		wait_idle();
		if (faults == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Guard against a hung handshake: far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
